// File: hw/rtl/drvp_pkg.sv
// ----------------------------------------------------------------------------
// drvp_pkg: shared types and constants for the distance ramp velocity profiler
// Holds the payload structs, request and run-state codes, register addresses,
// the back-end state type and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
package drvp_pkg;

    typedef enum logic [1:0] {
        REQ_POSE = 2'd0,
        REQ_HOLD = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    localparam logic [1:0] RUN_GO   = 2'd0;
    localparam logic [1:0] RUN_HELD = 2'd1;
    localparam logic [1:0] RUN_DONE = 2'd2;

    localparam logic [2:0] ADR_TARGET = 3'd0;
    localparam logic [2:0] ADR_MAXSPD = 3'd1;
    localparam logic [2:0] ADR_MINSPD = 3'd2;
    localparam logic [2:0] ADR_REV    = 3'd3;
    localparam logic [2:0] ADR_STEER  = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic               hold;
    } t_in;

    typedef struct packed {
        logic signed [16:0] speed_cmd;
        logic signed [15:0] steer_cmd;
        logic [1:0]         run_state;
    } t_out;

    // work handed from front to back: a step or a tick; a tick carries the
    // hold flag as it stood when the tick was taken
    typedef struct packed {
        logic        is_tick;
        logic        hold;
        logic [48:0] sq;      // dx^2+dy^2 for a step
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_DIV,
        BK_OUT
    } t_bk_state;

endpackage

// File: hw/rtl/distance_ramp_velocity_profiler_top.sv
// ----------------------------------------------------------------------------
// distance_ramp_velocity_profiler_top: triangular velocity profile generator
// Registers, front classifier, job queue and iterative back end.
// ----------------------------------------------------------------------------
// Hold items are taken straight away; a pose is squared in the front, then
// goes to the back for the bit-pair square root; a running tick goes
// through the 42-step restoring divide, while held and stop ticks finish
// straight from idle. The queue lets the front take items while the back
// computes, and each tick carries the hold flag it saw; the result waits in
// an output register until taken, and the back takes no new job meanwhile.
module distance_ramp_velocity_profiler_top
    import drvp_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0] r_target;
    logic [15:0] r_max, r_min, r_steer;
    logic        r_rev;
    logic        w_push, w_full, w_pop, w_empty;
    t_job        w_jin, w_jout;

    assign pready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0; r_max <= 16'd600; r_min <= 16'd100;
            r_rev <= 1'b0; r_steer <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                ADR_TARGET: r_target <= pwdata[23:0];
                ADR_MAXSPD: r_max    <= pwdata[15:0];
                ADR_MINSPD: r_min    <= pwdata[15:0];
                ADR_REV:    r_rev    <= pwdata[0];
                ADR_STEER:  r_steer  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            ADR_TARGET: prdata = {8'd0, r_target};
            ADR_MAXSPD: prdata = {16'd0, r_max};
            ADR_MINSPD: prdata = {16'd0, r_min};
            ADR_REV:    prdata = {31'd0, r_rev};
            ADR_STEER:  prdata = {16'd0, r_steer};
            default:    prdata = '0;
        endcase
    end

    drvp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_push(w_push), .o_job(w_jin), .i_full(w_full)
    );

    drvp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_jin), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_jout)
    );

    drvp_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_job(w_jout), .o_pop(w_pop),
        .i_target(r_target), .i_max(r_max), .i_min(r_min),
        .i_rev(r_rev), .i_steer(r_steer), .o_valid, .i_ready, .o_item
    );

endmodule

// File: hw/rtl/drvp_front.sv
// ----------------------------------------------------------------------------
// drvp_front: input classifier
// Accepts items, keeps the last position and the hold flag, and pushes
// step and tick jobs into the queue.
// ----------------------------------------------------------------------------
module drvp_front
    import drvp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_item,
    output logic  o_push,
    output t_job  o_job,
    input  logic  i_full
);

    logic signed [23:0] r_last_x, r_last_y;
    logic               r_have_last;
    logic               r_hold;
    logic signed [24:0] r_dx, r_dy;
    logic               r_sqv;
    logic               r_pend;        // square stage busy
    logic signed [49:0] w_sq;
    logic               w_acc;

    assign o_ready = !i_full && !r_pend;
    assign w_acc   = i_valid && o_ready;

    assign w_sq = r_dx * r_dx + r_dy * r_dy;

    // squaring from the registered differences; the step is pushed in the cycle after the pose
    always_comb begin
        o_push       = 1'b0;
        o_job.is_tick = 1'b0;
        o_job.hold   = r_hold;
        o_job.sq     = w_sq[48:0];
        if (r_pend) begin
            o_push = r_sqv;
        end else if (w_acc && t_req'(i_item.req_type) == REQ_TICK) begin
            o_push        = 1'b1;
            o_job.is_tick = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
            r_hold      <= 1'b0;
            r_pend      <= 1'b0;
            r_sqv       <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
        end else begin
            r_pend <= w_acc && t_req'(i_item.req_type) == REQ_POSE;
            if (w_acc) begin
                unique case (t_req'(i_item.req_type))
                    REQ_POSE: begin
                        r_dx        <= 25'(i_item.pos_x) - 25'(r_last_x);
                        r_dy        <= 25'(i_item.pos_y) - 25'(r_last_y);
                        r_sqv       <= r_have_last;
                        r_last_x    <= i_item.pos_x;
                        r_last_y    <= i_item.pos_y;
                        r_have_last <= 1'b1;
                    end
                    REQ_HOLD: r_hold <= i_item.hold;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/drvp_queue.sv
// ----------------------------------------------------------------------------
// drvp_queue: small job FIFO
// Register-based queue between front and back.
// ----------------------------------------------------------------------------
module drvp_queue
    import drvp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int AW = $clog2(DEPTH);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// File: hw/rtl/drvp_back.sv
// ----------------------------------------------------------------------------
// drvp_back: execution engine
// Integer square root and restoring divide, one bit a cycle; keeps the
// travelled distance and builds tick results in an output register.
// ----------------------------------------------------------------------------
module drvp_back
    import drvp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [23:0] i_target,
    input  logic [15:0] i_max,
    input  logic [15:0] i_min,
    input  logic        i_rev,
    input  logic [15:0] i_steer,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_item
);

    t_bk_state r_st, n_st;
    logic [31:0] r_trav;
    logic        r_fin;
    // sqrt: root is kept scaled by the current bit, so it needs the full width
    logic [49:0] r_rem;
    logic [49:0] r_root;
    logic [49:0] r_bit;
    // divide: numerator magnitude up to 16+25 bits
    logic [41:0] r_num;
    logic [24:0] r_drem;
    logic [5:0]  r_cnt;
    logic        r_neg, r_up;
    logic signed [16:0] r_base;
    logic        r_ov;
    t_out        r_out;

    logic [49:0] w_trial;
    logic [24:0] w_dsh;
    logic [32:0] w_d2;
    logic [32:0] w_ddiff;
    logic signed [16:0] w_delta;
    logic [16:0] w_dmag;
    logic [41:0] w_prod;
    logic [32:0] w_sum;
    logic signed [17:0] w_spd;
    logic signed [17:0] w_q;

    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign o_pop   = r_st == BK_IDLE && !i_empty && !r_ov;

    assign w_trial = r_rem - (r_root + r_bit);
    assign w_d2    = {r_trav, 1'b0};
    assign w_ddiff = w_d2 - 33'(i_target);
    assign w_delta = $signed({1'b0, i_max}) - $signed({1'b0, i_min});
    assign w_dmag  = w_delta[16] ? 17'(-w_delta) : 17'(w_delta);
    // |distance term| < T so fits 24 bits
    assign w_prod  = w_dmag * (w_d2 < 33'(i_target) ? w_d2[24:0] : w_ddiff[24:0]);
    assign w_dsh   = {r_drem[23:0], r_num[41]};
    assign w_sum   = 33'(r_trav) + 33'(r_root);
    assign w_q     = r_neg ? -$signed({1'b0, r_num[16:0]}) : $signed({1'b0, r_num[16:0]});
    assign w_spd   = r_up ? 18'(r_base) + w_q : 18'(r_base) - w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= BK_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE: if (o_pop) begin
                if (!i_job.is_tick)                          n_st = BK_SQRT;
                else if (!r_fin && !i_job.hold && r_trav < 32'(i_target)) n_st = BK_DIV;
            end
            BK_SQRT: if (r_bit == '0) n_st = BK_IDLE;
            BK_DIV:  if (r_cnt == '0) n_st = BK_OUT;
            BK_OUT:  n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trav <= '0;
            r_fin  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                BK_IDLE: if (o_pop) begin
                    r_rem  <= {1'b0, i_job.sq};
                    r_root <= '0;
                    r_bit  <= 50'd1 << 48;
                    r_num  <= w_prod;
                    r_drem <= '0;
                    r_cnt  <= 6'd41;
                    r_neg  <= w_delta[16];
                    r_up   <= w_d2 < 33'(i_target);
                    r_base <= w_d2 < 33'(i_target) ? $signed({1'b0, i_min})
                                                   : $signed({1'b0, i_max});
                    if (i_job.is_tick && !r_fin) begin
                        r_out.steer_cmd <= i_steer;
                        r_out.speed_cmd <= '0;
                        if (i_job.hold) begin
                            r_out.run_state <= RUN_HELD; r_ov <= 1'b1;
                        end else if (r_trav >= 32'(i_target)) begin
                            r_out.run_state <= RUN_DONE; r_ov <= 1'b1;
                            r_fin <= 1'b1;
                        end
                    end
                end
                BK_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_rem >= r_root + r_bit) begin
                            r_rem  <= w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_trav <= w_sum[32] ? '1 : w_sum[31:0];
                    end
                end
                BK_DIV: begin
                    // restoring divide, quotient bits shift into r_num
                    if (w_dsh >= 25'(i_target)) begin
                        r_drem <= w_dsh - 25'(i_target);
                        r_num  <= {r_num[40:0], 1'b1};
                    end else begin
                        r_drem <= w_dsh;
                        r_num  <= {r_num[40:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                end
                BK_OUT: begin
                    r_out.speed_cmd <= i_rev ? 17'(-w_spd) : 17'(w_spd);
                    r_out.run_state <= RUN_GO;
                    r_ov <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

// File: bench/drvp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drvp_checker: result predictor and scoreboard for the velocity profiler
// Follows the register port and the item channel to keep its own copy of
// the profiler state, queues the command each tick should give and checks
// every command taken from the output channel against it.
// ----------------------------------------------------------------------------
module drvp_checker
    import drvp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_item,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending,
    output logic [31:0] o_travelled
);

    // register copy
    logic [23:0] target_mm;
    logic [15:0] vmax;
    logic [15:0] vmin;
    logic        rev;
    logic [15:0] steer;

    // profiler state copy
    logic signed [23:0] prev_x;
    logic signed [23:0] prev_y;
    logic               prev_ok;
    logic [31:0]        dist_mm;
    logic               held;
    logic               done;

    t_out cmd_q[$];

    assign o_pending   = cmd_q.size();
    assign o_travelled = dist_mm;

    // integer square root, bit-pair method
    function automatic longint unsigned step_len(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // speed on the triangular ramp for the current distance
    function automatic logic [16:0] ramp_speed();
        longint t;
        longint d2;
        longint delta;
        longint spd;
        t     = longint'(target_mm);
        d2    = 2 * longint'(dist_mm);
        delta = longint'(vmax) - longint'(vmin);
        if (d2 < t)
            spd = longint'(vmin) + (delta * d2) / t;
        else
            spd = longint'(vmax) - (delta * (d2 - t)) / t;
        if (rev)
            spd = -spd;
        return spd[16:0];
    endfunction

    always @(posedge i_clk) begin
        longint          dx;
        longint          dy;
        longint unsigned sum;
        t_out            exp_cmd;
        t_out            got;
        int              nerr;
        if (!i_rst_n) begin
            target_mm <= '0;
            vmax      <= 16'd600;
            vmin      <= 16'd100;
            rev       <= 1'b0;
            steer     <= '0;
            prev_x    <= '0;
            prev_y    <= '0;
            prev_ok   <= 1'b0;
            dist_mm   <= '0;
            held      <= 1'b0;
            done      <= 1'b0;
            o_errors  <= 0;
            cmd_q.delete();
        end else begin
            nerr = 0;
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    ADR_TARGET: target_mm <= i_pwdata[23:0];
                    ADR_MAXSPD: vmax      <= i_pwdata[15:0];
                    ADR_MINSPD: vmin      <= i_pwdata[15:0];
                    ADR_REV:    rev       <= i_pwdata[0];
                    ADR_STEER:  steer     <= i_pwdata[15:0];
                    default: ;
                endcase
            end

            // input transaction
            if (i_in_valid && i_in_ready) begin
                case (t_req'(i_in_item.req_type))
                    REQ_POSE: begin
                        if (prev_ok) begin
                            dx  = longint'(i_in_item.pos_x) - longint'(prev_x);
                            dy  = longint'(i_in_item.pos_y) - longint'(prev_y);
                            sum = longint'(dist_mm) + step_len(dx * dx + dy * dy);
                            dist_mm <= (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                        end
                        prev_x  <= i_in_item.pos_x;
                        prev_y  <= i_in_item.pos_y;
                        prev_ok <= 1'b1;
                    end
                    REQ_HOLD: held <= i_in_item.hold;
                    REQ_TICK: begin
                        if (!done) begin
                            exp_cmd.steer_cmd = steer;
                            if (held) begin
                                exp_cmd.speed_cmd = '0;
                                exp_cmd.run_state = RUN_HELD;
                            end else if (dist_mm >= {8'd0, target_mm}) begin
                                done <= 1'b1;
                                exp_cmd.speed_cmd = '0;
                                exp_cmd.run_state = RUN_DONE;
                            end else begin
                                exp_cmd.speed_cmd = ramp_speed();
                                exp_cmd.run_state = RUN_GO;
                            end
                            cmd_q.push_back(exp_cmd);
                        end
                    end
                    default: ;
                endcase
            end

            // output transaction
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (cmd_q.size() == 0) begin
                    $error("unexpected command: speed %0d steer %0d state %0d",
                           got.speed_cmd, got.steer_cmd, got.run_state);
                    nerr++;
                end else begin
                    exp_cmd = cmd_q.pop_front();
                    if (got.speed_cmd !== exp_cmd.speed_cmd) begin
                        $error("speed_cmd expected %0d actual %0d",
                               exp_cmd.speed_cmd, got.speed_cmd);
                        nerr++;
                    end
                    if (got.steer_cmd !== exp_cmd.steer_cmd) begin
                        $error("steer_cmd expected %0d actual %0d",
                               exp_cmd.steer_cmd, got.steer_cmd);
                        nerr++;
                    end
                    if (got.run_state !== exp_cmd.run_state) begin
                        $error("run_state expected %0d actual %0d",
                               exp_cmd.run_state, got.run_state);
                        nerr++;
                    end
                end
            end
            o_errors <= o_errors + nerr;
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level bench for the distance ramp velocity profiler
// Drives pose, hold, tick and none items plus register writes through several
// profile settings and idle patterns; drvp_checker judges every command.
// ----------------------------------------------------------------------------
module tb;
    import drvp_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_item = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    logic [31:0] dist_now;
    int          send_idle;
    int          recv_idle;
    int          cur_x;
    int          cur_y;

    always #5 i_clk = ~i_clk;

    distance_ramp_velocity_profiler_top uut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item, .o_valid, .i_ready, .o_item,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    drvp_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_item(o_item),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending), .o_travelled(dist_now)
    );

    // receiver stalls
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog: cycles with no transaction on the item channels or the register port
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic reg_write(logic [2:0] adr, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {adr, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one item transaction; valid stays high into the next call
    task automatic send(t_req kind, int x, int y, logic h);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_item.req_type <= kind;
        i_item.pos_x    <= x[23:0];
        i_item.pos_y    <= y[23:0];
        i_item.hold     <= h;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // pose a short random step away, reflected at the coordinate limits
    task automatic walk();
        int nx;
        int ny;
        int dx;
        int dy;
        dx = int'($urandom_range(1200)) - 600;
        dy = int'($urandom_range(1200)) - 600;
        nx = cur_x + dx;
        ny = cur_y + dy;
        if (nx > 8388607 || nx < -8388608) nx = cur_x - dx;
        if (ny > 8388607 || ny < -8388608) ny = cur_y - dy;
        cur_x = nx;
        cur_y = ny;
        send(REQ_POSE, cur_x, cur_y, 1'($urandom_range(1)));
    endtask

    // idle the input channel until every command is back and the core is quiet
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_target(int lo, int hi);
        longint t;
        t = 2 * longint'(dist_now) + $urandom_range(hi, lo);
        if (t > 24'hFF_FFFF) t = 24'hFF_FFFF;
        reg_write(ADR_TARGET, t[31:0]);
    endtask

    initial begin
        int ph;
        int n;
        int r;
        send_idle = 33;
        recv_idle = 55;
        cur_x = 8388607;
        cur_y = -8388608;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme registers and the special cases
        reg_write(ADR_TARGET, 32'h00FF_FFFF);
        reg_write(ADR_MAXSPD, 32'd65535);
        reg_write(ADR_MINSPD, 32'd0);
        reg_write(ADR_REV, 32'd0);
        reg_write(ADR_STEER, 32'h0000_7FFF);
        send(REQ_POSE, cur_x, cur_y, 1'b1);
        send(REQ_TICK, 0, 0, 1'b0);
        send(REQ_NONE, -1, -1, 1'b1);
        send(REQ_HOLD, 0, 0, 1'b1);
        send(REQ_TICK, -1, -1, 1'b1);
        send(REQ_POSE, cur_x, cur_y, 1'b0);
        send(REQ_TICK, 0, 0, 1'b0);
        send(REQ_HOLD, -1, -1, 1'b0);
        for (n = 0; n < 6; n++) walk();
        send(REQ_TICK, 0, 0, 1'b0);
        send(REQ_NONE, 0, 0, 1'b0);
        send(REQ_TICK, 0, 0, 1'b0);

        // random phases over several profile settings
        for (ph = 0; ph < 6; ph++) begin
            drain();
            send_idle = (ph < 2) ? 33 : (ph < 4) ? 55 : 0;
            recv_idle = (ph < 2) ? 55 : (ph < 4) ? 33 : 0;
            set_target(30000, 120000);
            case (ph)
                1: begin
                    reg_write(ADR_MAXSPD, 32'd0);
                    reg_write(ADR_MINSPD, 32'd65535);
                    reg_write(ADR_REV, 32'd1);
                    reg_write(ADR_STEER, 32'hFFFF_8000);
                end
                3: begin
                    reg_write(ADR_MAXSPD, 32'd500);
                    reg_write(ADR_MINSPD, 32'd500);
                    reg_write(ADR_REV, 32'd0);
                    reg_write(ADR_STEER, 32'd0);
                end
                default: begin
                    reg_write(ADR_MAXSPD, $urandom_range(65535));
                    reg_write(ADR_MINSPD, $urandom_range(65535));
                    reg_write(ADR_REV, $urandom_range(1));
                    reg_write(ADR_STEER, $urandom);
                end
            endcase
            for (n = 0; n < 38; n++) begin
                r = $urandom_range(99);
                if (r < 55)
                    walk();
                else if (r < 85)
                    send(REQ_TICK, $urandom, $urandom, 1'($urandom_range(1)));
                else if (r < 94)
                    send(REQ_HOLD, $urandom, $urandom, $urandom_range(3) == 0);
                else
                    send(REQ_NONE, $urandom, $urandom, 1'($urandom_range(1)));
            end
        end

        // stop sequence: zero target, hold outranks stop, silence after stop
        drain();
        reg_write(ADR_TARGET, 32'd0);
        send(REQ_HOLD, 0, 0, 1'b1);
        send(REQ_TICK, 0, 0, 1'b0);
        send(REQ_HOLD, 0, 0, 1'b0);
        send(REQ_TICK, 0, 0, 1'b0);
        send(REQ_TICK, 0, 0, 1'b0);
        send(REQ_HOLD, 0, 0, 1'b1);
        send(REQ_TICK, 0, 0, 1'b0);
        // full-range jumps until the distance saturates
        for (n = 0; n < 200; n++) begin
            if (n[0])
                send(REQ_POSE, 8388607, -8388608, 1'b0);
            else
                send(REQ_POSE, -8388608, 8388607, 1'b1);
        end
        send(REQ_TICK, 0, 0, 1'b0);
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: distance_ramp_velocity_profiler_top.f
hw/rtl/drvp_pkg.sv
hw/rtl/drvp_front.sv
hw/rtl/drvp_queue.sv
hw/rtl/drvp_back.sv
hw/rtl/distance_ramp_velocity_profiler_top.sv
bench/drvp_checker.sv
bench/tb.sv
